/* src/ofvf_pkg.sv */
// Shared types, step codes and fixed-point helpers for the optical flow velocity filter.
package ofvf_pkg;

  typedef logic [4:0] step_t;

  typedef struct packed {
    logic  post;
    step_t step;
  } seq_ctl_t;

  // Error polynomial and error limits
  localparam step_t S_SQ   = 5'd0;
  localparam step_t S_CUBE = 5'd1;
  localparam step_t S_PC3  = 5'd2;
  localparam step_t S_PC2  = 5'd3;
  localparam step_t S_PC1  = 5'd4;
  localparam step_t S_EABS = 5'd5;
  localparam step_t S_PERR = 5'd6;
  // Scaling and rotation compensation
  localparam step_t S_SX   = 5'd7;
  localparam step_t S_SY   = 5'd8;
  localparam step_t S_RX1  = 5'd9;
  localparam step_t S_RX2  = 5'd10;
  localparam step_t S_RX3  = 5'd11;
  localparam step_t S_RXA  = 5'd12;
  localparam step_t S_RY1  = 5'd13;
  localparam step_t S_RY2  = 5'd14;
  localparam step_t S_RY3  = 5'd15;
  localparam step_t S_RYA  = 5'd16;
  // Displacement filters
  localparam step_t S_F0A  = 5'd17;
  localparam step_t S_F0B  = 5'd18;
  localparam step_t S_F0C  = 5'd19;
  localparam step_t S_F1A  = 5'd20;
  localparam step_t S_F1B  = 5'd21;
  localparam step_t S_F1C  = 5'd22;
  // Velocity and filters
  localparam step_t S_VX   = 5'd23;
  localparam step_t S_F2A  = 5'd24;
  localparam step_t S_F2B  = 5'd25;
  localparam step_t S_F2C  = 5'd26;
  localparam step_t S_VY   = 5'd27;
  localparam step_t S_F3A  = 5'd28;
  localparam step_t S_F3B  = 5'd29;
  localparam step_t S_F3C  = 5'd30;
  localparam step_t S_HLTH = 5'd31;

  localparam step_t S_LAST = S_HLTH;

  localparam logic [2:0] REG_CALIB   = 3'd0;
  localparam logic [2:0] REG_CUBIC   = 3'd1;
  localparam logic [2:0] REG_SQUARE  = 3'd2;
  localparam logic [2:0] REG_LINEAR  = 3'd3;
  localparam logic [2:0] REG_CONST   = 3'd4;
  localparam logic [2:0] REG_GAIN    = 3'd5;
  localparam logic [2:0] REG_FEEDBK  = 3'd6;
  localparam logic [2:0] REG_STEP    = 3'd7;

  localparam logic signed [31:0] Q_ONE      = 32'sd65536;
  localparam logic signed [31:0] Q_TENTH    = 32'sd6554;
  localparam logic [30:0]        ERR_BIG    = 31'd65536000;
  localparam logic [7:0]         QUAL_FLOOR = 8'd10;
  localparam logic [7:0]         QUAL_GOOD  = 8'd70;
  localparam int                 FAIL_LIMIT = 50;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] sat31(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 31'h7fffffff;
    end else if (v < 64'sd0) begin
      return 31'd0;
    end
    return v[30:0];
  endfunction

  // Q16.16 product: floor shift by 16, then saturate.
  function automatic logic signed [31:0] qpost(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

endpackage

/* src/ofvf_mul.sv */
// Shared registered 32 x 32 signed multiplier.
module ofvf_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

/* src/ofvf_seq.sv */
// Sequencer: handshake state machine, step counter and issue/post phase.
module ofvf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ofvf_pkg::step_t start_step,
  output ofvf_pkg::seq_ctl_t ctl
);
  import ofvf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  step_t  step;
  logic   phase;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign ctl.post  = (state == ST_RUN) && phase;
  assign ctl.step  = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      phase <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            step  <= start_step;
            phase <= 1'b0;
          end
        end
        ST_RUN: begin
          // Each step issues a product, then consumes it in the next cycle.
          phase <= ~phase;
          if (phase) begin
            if (step == S_LAST) begin
              state <= ST_DONE;
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* src/optical_flow_velocity_filter.sv */
// Top level: configuration registers, item registers and shared-multiplier datapath.
// Usage:
// An input request (status, deltas, quality, three rates, height) is taken on
// in_valid & in_ready. The block then runs a 32-step program on one shared
// 32 x 32 multiplier; each step issues a product, then post-processes it. A
// motion-valid request runs all steps, an overflow request starts at the
// displacement filters and one with neither bit at the velocity steps.
// in_ready is low from acceptance until the result has been taken.
// The result request is presented with out_valid and held stable until
// out_ready; while the receiver stalls no new input is taken.
// Configuration writes use cfg_valid/cfg_ready (always ready), cfg_index and
// cfg_data, and are meant to be issued while the block is idle.
// Reset (synchronous, rst high) clears the filter, held and health state, sets
// calib_scale to 1.0, step_time to 164 and the other config registers to zero.
// Throughput is set by the multiplier being used once per step.
module optical_flow_velocity_filter #(
  parameter int LOOP_RATE_HZ = 400,
  parameter int HEALTH_MAX   = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         motion_status,
  input  logic signed [7:0]  delta_x,
  input  logic signed [7:0]  delta_y,
  input  logic [7:0]         surface_quality,
  input  logic signed [31:0] rate_roll,
  input  logic signed [31:0] rate_pitch,
  input  logic signed [31:0] rate_yaw,
  input  logic [30:0]        ground_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] disp_x,
  output logic signed [31:0] disp_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic [7:0]         quality_out,
  output logic [30:0]        vel_error,
  output logic [30:0]        pos_error,
  output logic               sensor_failed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ofvf_pkg::*;

  localparam int HW = $clog2(HEALTH_MAX + 1);

  logic signed [31:0] calib_scale, coef_cubic, coef_square, coef_linear, coef_constant;
  logic signed [31:0] filter_input_gain, filter_feedback;
  logic [16:0]        step_time;

  logic signed [7:0]  it_dx, it_dy;
  logic [7:0]         it_q;
  logic signed [31:0] it_roll, it_pitch, it_yaw;
  logic [30:0]        it_h;

  logic signed [31:0] ra, rb, xs, ys;
  logic signed [63:0] acc;
  logic [30:0]        err_e;
  logic signed [31:0] pin [4];
  logic signed [31:0] pout [4];
  logic [HW-1:0]      health_count;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  step_t              start_step;
  seq_ctl_t           ctl;
  logic               accept;
  logic [7:0]         q_clamp;
  logic [1:0]         fk;
  logic signed [31:0] fsrc;
  logic signed [31:0] fout;
  logic signed [32:0] hdiff;
  logic [32:0]        habs;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_clamp   = (surface_quality < QUAL_FLOOR) ? QUAL_FLOOR : surface_quality;

  always_comb begin
    if (motion_status[0]) begin
      start_step = S_SQ;
    end else if (motion_status[4]) begin
      start_step = S_F0A;
    end else begin
      start_step = S_VX;
    end
  end

  ofvf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .start_step (start_step),
    .ctl        (ctl)
  );

  ofvf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Filter index and sample source for the filter steps.
  always_comb begin
    case (ctl.step)
      S_F0A, S_F0B, S_F0C: fk = 2'd0;
      S_F1A, S_F1B, S_F1C: fk = 2'd1;
      S_F2A, S_F2B, S_F2C: fk = 2'd2;
      default:             fk = 2'd3;
    endcase
  end
  assign fsrc = fk[0] ? ys : xs;
  assign fout = sat32(64'(pin[fk]) + 64'(ra) + 64'(rb));

  always_comb begin
    case (ctl.step)
      S_SQ:   begin mul_a = {24'd0, it_q}; mul_b = {24'd0, it_q}; end
      S_CUBE: begin mul_a = rb; mul_b = {24'd0, it_q}; end
      S_PC3:  begin mul_a = coef_cubic; mul_b = ra; end
      S_PC2:  begin mul_a = coef_square; mul_b = rb; end
      S_PC1:  begin mul_a = coef_linear; mul_b = {24'd0, it_q}; end
      S_PERR: begin mul_a = {1'b0, err_e}; mul_b = {15'd0, step_time}; end
      S_SX:   begin mul_a = 32'(it_dx); mul_b = calib_scale; end
      S_SY:   begin mul_a = 32'(it_dy); mul_b = calib_scale; end
      S_RX1:  begin mul_a = it_pitch; mul_b = {1'b0, it_h}; end
      S_RY1:  begin mul_a = it_roll; mul_b = {1'b0, it_h}; end
      S_RX2, S_RY2: begin mul_a = ra; mul_b = {15'd0, step_time}; end
      S_RX3, S_RY3: begin mul_a = ra; mul_b = Q_TENTH; end
      S_F0A, S_F1A, S_F2A, S_F3A: begin mul_a = fsrc; mul_b = filter_input_gain; end
      S_F0B, S_F1B, S_F2B, S_F3B: begin mul_a = filter_feedback; mul_b = pout[fk]; end
      S_VX:   begin mul_a = disp_x; mul_b = 32'(LOOP_RATE_HZ); end
      S_VY:   begin mul_a = disp_y; mul_b = 32'(LOOP_RATE_HZ); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign hdiff = 33'(pout[3]) - 33'(it_yaw);
  assign habs  = hdiff[32] ? 33'(-hdiff) : hdiff;

  assign vel_x         = pout[2];
  assign vel_y         = pout[3];
  assign sensor_failed = (health_count > HW'(FAIL_LIMIT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_scale       <= Q_ONE;
      coef_cubic        <= '0;
      coef_square       <= '0;
      coef_linear       <= '0;
      coef_constant     <= '0;
      filter_input_gain <= '0;
      filter_feedback   <= '0;
      step_time         <= 17'd164;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CALIB:  calib_scale       <= cfg_data;
        REG_CUBIC:  coef_cubic        <= cfg_data;
        REG_SQUARE: coef_square       <= cfg_data;
        REG_LINEAR: coef_linear       <= cfg_data;
        REG_CONST:  coef_constant     <= cfg_data;
        REG_GAIN:   filter_input_gain <= cfg_data;
        REG_FEEDBK: filter_feedback   <= cfg_data;
        REG_STEP:   step_time         <= cfg_data[16:0];
        default:    step_time         <= step_time;
      endcase
    end
  end

  // Item registers and scratch datapath (no reset needed).
  always_ff @(posedge clk) begin
    if (accept) begin
      it_dx    <= delta_x;
      it_dy    <= delta_y;
      it_q     <= q_clamp;
      it_roll  <= rate_roll;
      it_pitch <= rate_pitch;
      it_yaw   <= rate_yaw;
      it_h     <= ground_height;
      xs       <= disp_x;
      ys       <= disp_y;
    end else if (ctl.post) begin
      case (ctl.step)
        S_SQ:   rb <= prod[31:0];
        S_CUBE: ra <= prod[31:0];
        S_PC3:  acc <= prod;
        S_PC2:  acc <= acc + prod;
        S_PC1:  acc <= acc + prod + 64'(coef_constant);
        S_EABS: err_e <= sat31(acc[63] ? -acc : acc);
        S_SX, S_VX: xs <= sat32(prod);
        S_SY, S_VY: ys <= sat32(prod);
        S_RX1, S_RX2, S_RX3, S_RY1, S_RY2, S_RY3: ra <= qpost(prod);
        S_RXA:  xs <= sat32(64'(xs) + 64'(ra));
        S_RYA:  ys <= sat32(64'(ys) - 64'(ra));
        S_F0A, S_F1A, S_F2A, S_F3A: ra <= qpost(prod);
        S_F0B, S_F1B, S_F2B, S_F3B: rb <= qpost(prod);
        default: ra <= ra;
      endcase
    end
  end

  // Filter, held and health state
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_x       <= '0;
      disp_y       <= '0;
      quality_out  <= '0;
      vel_error    <= '0;
      pos_error    <= '0;
      health_count <= '0;
      for (int k = 0; k < 4; k++) begin
        pin[k]  <= '0;
        pout[k] <= '0;
      end
    end else if (accept) begin
      if (motion_status[0]) begin
        quality_out <= q_clamp;
      end else if (motion_status[4]) begin
        quality_out <= 8'd1;
        vel_error   <= ERR_BIG;
        pos_error   <= ERR_BIG;
      end
    end else if (ctl.post) begin
      case (ctl.step)
        S_PERR: begin
          if (it_q < QUAL_GOOD) begin
            vel_error <= ERR_BIG;
            pos_error <= ERR_BIG;
          end else begin
            vel_error <= err_e;
            pos_error <= sat31(prod >>> 16);
          end
        end
        S_F0C, S_F1C, S_F2C, S_F3C: begin
          pin[fk]  <= ra;
          pout[fk] <= fout;
          if (fk == 2'd0) begin
            disp_x <= fout;
          end else if (fk == 2'd1) begin
            disp_y <= fout;
          end
        end
        S_HLTH: begin
          if (habs >= 33'd65536) begin
            if (health_count < HW'(HEALTH_MAX)) begin
              health_count <= health_count + 1'b1;
            end
          end else if (health_count != '0) begin
            health_count <= health_count - 1'b1;
          end
        end
        default: health_count <= health_count;
      endcase
    end
  end
endmodule
